// ===== hw/rtl/clfe_pkg.sv =====
// Shared types and constants for the copier link frame engine.
// No dependencies; imported by every module of the block.
`default_nettype none
package clfe_pkg;

   localparam logic [7:0] SYNC0    = 8'hD5;
   localparam logic [7:0] SYNC1    = 8'hAA;
   localparam logic [7:0] SYNC2    = 8'h96;
   localparam logic [7:0] CHK_SEED = 8'h81;

   localparam int REQ_DATA_W = 56;
   localparam int RSP_USER_W = 3;

   typedef enum logic [1:0] {
      REQ_START  = 2'd0,
      REQ_DATA   = 2'd1,
      REQ_STATUS = 2'd2,
      REQ_BAD    = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      KIND_TX      = 2'd0,
      KIND_RX      = 2'd1,
      KIND_VERDICT = 2'd2,
      KIND_REJECT  = 2'd3
   } out_kind_type;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_WRITE = 2'd1,
      PH_RDATA = 2'd2,
      PH_RCHK  = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      OP_SINGLE = 2'd0,
      OP_PAIR   = 2'd1,
      OP_HDR    = 2'd2,
      OP_HDR_ZW = 2'd3
   } op_type;

   localparam logic [7:0] CMD_WRITE = 8'd0;
   localparam logic [7:0] CMD_READ  = 8'd1;

   // one queued job for the back end
   typedef struct packed {
      op_type       op;
      out_kind_type kind;
      logic [7:0]   b0;    // single byte, first of a pair, or header code
      logic [7:0]   b1;    // second of a pair, or header checksum
      logic         last;
      logic         bad;
      logic [15:0]  address;
      logic [15:0]  length;
   } job_type;

   localparam int JOB_W = $bits(job_type);

endpackage
`default_nettype wire

// ===== hw/rtl/clfe_front.sv =====
// Front end: accepts requests, tracks the link phase and checksum, and
// queues one job per request that produces results. Uses clfe_pkg.
`default_nettype none
module clfe_front (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_fire,
   input  wire  [1:0]                   req_kind,
   input  wire  [clfe_pkg::REQ_DATA_W-1:0] req_data,
   output logic                         push,
   output clfe_pkg::job_type            push_job
);
   import clfe_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [15:0] left_ff, left_in;
   logic [7:0]  chk_ff, chk_in;
   logic        high_ff, high_in;
   logic [3:0]  nib_ff, nib_in;

   logic [7:0]  cmd_code, data_byte, status_sample, rx_byte, chk_x;
   logic [15:0] address, length, left_dec;

   assign cmd_code      = req_data[7:0];
   assign address       = req_data[23:8];
   assign length        = req_data[39:24];
   assign data_byte     = req_data[47:40];
   assign status_sample = req_data[55:48];
   assign rx_byte       = {status_sample[6:3], nib_ff};
   assign left_dec      = left_ff - 16'd1;

   always_comb begin
      phase_in = phase_ff;
      left_in  = left_ff;
      chk_in   = chk_ff;
      high_in  = high_ff;
      nib_in   = nib_ff;
      push     = 1'b0;
      chk_x    = chk_ff ^ data_byte;
      push_job = '{op: OP_SINGLE, kind: KIND_REJECT, b0: 8'd0, b1: 8'd0,
                   last: 1'b1, bad: 1'b0, address: address, length: length};
      if (req_fire) begin
         push = 1'b1;
         case (req_kind)
            REQ_START: begin
               if (phase_ff == PH_IDLE) begin
                  push_job.op   = (cmd_code == CMD_WRITE && length == 16'd0) ?
                                  OP_HDR_ZW : OP_HDR;
                  push_job.kind = KIND_TX;
                  push_job.b0   = cmd_code;
                  push_job.b1   = CHK_SEED ^ cmd_code ^ address[7:0] ^ address[15:8]
                                  ^ length[7:0] ^ length[15:8];
                  chk_in  = CHK_SEED;
                  left_in = length;
                  high_in = 1'b0;
                  nib_in  = 4'd0;
                  if (cmd_code == CMD_WRITE)
                     phase_in = (length == 16'd0) ? PH_IDLE : PH_WRITE;
                  else if (cmd_code == CMD_READ)
                     phase_in = (length == 16'd0) ? PH_RCHK : PH_RDATA;
               end
            end
            REQ_DATA: begin
               if (phase_ff == PH_WRITE) begin
                  chk_in        = chk_x;
                  left_in       = left_dec;
                  push_job.kind = KIND_TX;
                  push_job.b0   = data_byte;
                  push_job.b1   = chk_x;
                  push_job.last = 1'b0;
                  if (left_dec == 16'd0) begin
                     push_job.op = OP_PAIR;
                     phase_in    = PH_IDLE;
                  end
               end
            end
            REQ_STATUS: begin
               if (phase_ff == PH_RDATA || phase_ff == PH_RCHK) begin
                  if (!high_ff) begin
                     push    = 1'b0;
                     nib_in  = status_sample[6:3];
                     high_in = 1'b1;
                  end else begin
                     high_in     = 1'b0;
                     push_job.b0 = rx_byte;
                     if (phase_ff == PH_RDATA) begin
                        chk_in        = chk_ff ^ rx_byte;
                        left_in       = left_dec;
                        push_job.kind = KIND_RX;
                        push_job.last = 1'b0;
                        if (left_dec == 16'd0)
                           phase_in = PH_RCHK;
                     end else begin
                        push_job.kind = KIND_VERDICT;
                        push_job.bad  = (rx_byte != chk_ff);
                        phase_in      = PH_IDLE;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         left_ff  <= 16'd0;
         chk_ff   <= CHK_SEED;
         high_ff  <= 1'b0;
         nib_ff   <= 4'd0;
      end else begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
         chk_ff   <= chk_in;
         high_ff  <= high_in;
         nib_ff   <= nib_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/clfe_queue.sv =====
// Short job queue between the front and back ends.
// Uses clfe_pkg for the job record.
`default_nettype none
module clfe_queue #(
   parameter int DEPTH = 4
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                push,
   input  clfe_pkg::job_type  push_job,
   output logic               full,
   input  wire                pop,
   output logic               head_valid,
   output clfe_pkg::job_type  head_job
);
   import clfe_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   job_type           store_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign full       = (cnt_ff == CNT_W'(DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_job   = store_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push)
         wr_in = (wr_ff == LAST_PTR) ? '0 : wr_ff + PTR_W'(1);
      if (do_pop)
         rd_in = (rd_ff == LAST_PTR) ? '0 : rd_ff + PTR_W'(1);
      if (do_push && !do_pop)
         cnt_in = cnt_ff + CNT_W'(1);
      else if (!do_push && do_pop)
         cnt_in = cnt_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (do_push)
         store_ff[wr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/clfe_back.sv =====
// Back end: expands queued jobs into response beats (headers, byte pairs,
// single results) through a registered output stage. Uses clfe_pkg.
`default_nettype none
module clfe_back (
   input  wire                clock,
   input  wire                reset,
   input  wire                head_valid,
   input  clfe_pkg::job_type  head_job,
   output logic               pop,
   output logic               rsp_tvalid,
   input  wire                rsp_tready,
   output logic [7:0]         rsp_tdata,
   output logic               rsp_tlast,
   output logic [clfe_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import clfe_pkg::*;

   logic [3:0]   beat_ff, beat_in;
   logic         valid_ff, valid_in;
   logic [7:0]   byte_ff, byte_in;
   logic         last_ff, last_in;
   logic         bad_ff, bad_in;
   out_kind_type kind_ff, kind_in;
   logic         load, final_beat;

   assign load = head_valid && (!valid_ff || rsp_tready);

   always_comb begin
      kind_in    = head_job.kind;
      bad_in     = head_job.bad;
      byte_in    = head_job.b0;
      last_in    = head_job.last;
      final_beat = 1'b1;
      unique case (head_job.op)
         OP_SINGLE: ;
         OP_PAIR: begin
            final_beat = (beat_ff == 4'd1);
            byte_in    = (beat_ff == 4'd1) ? head_job.b1 : head_job.b0;
            last_in    = (beat_ff == 4'd1);
         end
         OP_HDR, OP_HDR_ZW: begin
            last_in = 1'b0;
            case (beat_ff)
               4'd0:    byte_in = SYNC0;
               4'd1:    byte_in = SYNC1;
               4'd2:    byte_in = SYNC2;
               4'd3:    byte_in = head_job.b0;
               4'd4:    byte_in = head_job.address[7:0];
               4'd5:    byte_in = head_job.address[15:8];
               4'd6:    byte_in = head_job.length[7:0];
               4'd7:    byte_in = head_job.length[15:8];
               4'd8:    byte_in = head_job.b1;
               default: byte_in = CHK_SEED;
            endcase
            if (head_job.op == OP_HDR) begin
               final_beat = (beat_ff == 4'd8);
               last_in    = (beat_ff == 4'd8) && (head_job.b0 > CMD_READ);
            end else begin
               final_beat = (beat_ff == 4'd9);
               last_in    = (beat_ff == 4'd9);
            end
         end
         default: ;
      endcase
      pop      = load && final_beat;
      beat_in  = beat_ff;
      if (load)
         beat_in = final_beat ? 4'd0 : beat_ff + 4'd1;
      valid_in = load ? 1'b1 : (valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         beat_ff  <= 4'd0;
      end else begin
         valid_ff <= valid_in;
         beat_ff  <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= byte_in;
         last_ff <= last_in;
         bad_ff  <= bad_in;
         kind_ff <= kind_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = {bad_ff, kind_ff};

endmodule
`default_nettype wire

// ===== hw/rtl/copier_link_frame_engine_core.sv =====
// Path: a request's first response beat passes through the queue write, then the output
// register. Throughput: 1 request per cycle;
// a start command takes 9 beats (10 for a zero-length write), the last byte of a write 2.
// Input stalls only while the job queue holds QUEUE_DEPTH jobs.
// Reset: synchronous, active high; phase idle, queue empty, output invalid.
// Top level: front end, job queue and back end; depends on clfe_pkg.
`default_nettype none
module copier_link_frame_engine_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire [clfe_pkg::REQ_DATA_W-1:0] req_tdata, // cmd_code, address, length,
                                                      // data_byte, status_sample
   input  wire [1:0]  req_tuser,                      // req_type
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [7:0] rsp_tdata,                      // out_byte
   output logic       rsp_tlast,                      // last
   output logic [clfe_pkg::RSP_USER_W-1:0] rsp_tuser  // out_kind, checksum_bad
);
   import clfe_pkg::*;

   logic    push, full, pop, head_valid, req_fire;
   job_type push_job, head_job;

   assign req_tready = !full;
   assign req_fire   = req_tvalid && req_tready;

   clfe_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .req_kind (req_tuser),
      .req_data (req_tdata),
      .push     (push),
      .push_job (push_job)
   );

   clfe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   clfe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire

// ===== hw/rtl/clfe_checker.sv =====
// Port-level checks for the copier link frame engine, bound to the top.
// Uses clfe_pkg for result kinds.
`default_nettype none
module clfe_checker (
   input wire       clock,
   input wire       reset,
   input wire       rsp_tvalid,
   input wire       rsp_tready,
   input wire [7:0] rsp_tdata,
   input wire       rsp_tlast,
   input wire [clfe_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import clfe_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_reject: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] == KIND_REJECT |-> rsp_tlast && rsp_tdata == 8'd0)
      else $error("malformed rejection");

   a_bad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> rsp_tuser[1:0] == KIND_VERDICT && rsp_tlast)
      else $error("checksum flag outside verdict");

   a_rx: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] == KIND_RX |-> !rsp_tlast)
      else $error("received byte marked last");

endmodule

bind copier_link_frame_engine_core clfe_checker u_clfe_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
